@@ rtl/scit_pkg.sv @@
// Shared types, codes and helpers for the sound-CPU I/O register and timer unit.
package scit_pkg;

   localparam int NUM_TIMERS   = 3;
   localparam int NUM_PORTS    = 4;
   localparam int NUM_AUX      = 2;

   localparam int SLOW_TIMER_PERIOD_DEF = 128;
   localparam int FAST_TIMER_PERIOD_DEF = 16;
   localparam int TICKS_PER_ACCESS_DEF  = 2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      OP_IDLE       = 3'd0,
      OP_CPU_READ   = 3'd1,
      OP_CPU_WRITE  = 3'd2,
      OP_HOST_READ  = 3'd3,
      OP_HOST_WRITE = 3'd4
   } op_type;

   // I/O register offsets from F0
   localparam logic [3:0] ADDR_TEST     = 4'h0;
   localparam logic [3:0] ADDR_CONTROL  = 4'h1;
   localparam logic [3:0] ADDR_DSP_ADDR = 4'h2;
   localparam logic [3:0] ADDR_DSP_DATA = 4'h3;
   localparam logic [3:0] ADDR_PORT0    = 4'h4;
   localparam logic [3:0] ADDR_PORT1    = 4'h5;
   localparam logic [3:0] ADDR_PORT2    = 4'h6;
   localparam logic [3:0] ADDR_PORT3    = 4'h7;
   localparam logic [3:0] ADDR_AUX0     = 4'h8;
   localparam logic [3:0] ADDR_AUX1     = 4'h9;
   localparam logic [3:0] ADDR_TARGET0  = 4'hA;
   localparam logic [3:0] ADDR_TARGET1  = 4'hB;
   localparam logic [3:0] ADDR_TARGET2  = 4'hC;
   localparam logic [3:0] ADDR_COUNTER0 = 4'hD;
   localparam logic [3:0] ADDR_COUNTER1 = 4'hE;
   localparam logic [3:0] ADDR_COUNTER2 = 4'hF;

   // TEST register bits
   localparam int TEST_TIMER_DISABLE_BIT = 0;
   localparam int TEST_RAM_WRITE_BIT     = 1;
   localparam int TEST_RAM_BLOCK_BIT     = 2;
   localparam int TEST_TIMER_ENABLE_BIT  = 3;
   localparam logic [7:0] TEST_RESET     = 8'h0A;

   // CONTROL register bits
   localparam int CTRL_CLEAR_LOW_BIT  = 4;
   localparam int CTRL_CLEAR_HIGH_BIT = 5;
   localparam int CTRL_BOOT_ROM_BIT   = 7;

   typedef struct packed {
      logic [7:0] prescale;
      logic       toggle;
      logic       gated;
      logic       on;
      logic [7:0] target;
      logic [7:0] divider;
      logic [3:0] tick;
   } timer_type;

   // Resample the gated line; a falling edge steps the divider against its target.
   // Target 0 behaves as 256 because the divider wraps back to 0.
   function automatic timer_type timer_sync(timer_type tm, logic [7:0] test);
      timer_type r;
      logic      level;
      logic      fall;
      r     = tm;
      level = tm.toggle & test[TEST_TIMER_ENABLE_BIT] & ~test[TEST_TIMER_DISABLE_BIT];
      fall  = tm.gated & ~level;
      r.gated = level;
      if (fall && tm.on) begin
         r.divider = tm.divider + 8'd1;
         if (r.divider == tm.target) begin
            r.divider = '0;
            r.tick    = tm.tick + 4'd1;
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/sound_cpu_io_timer_unit_top.sv @@
// Top level of the sound-CPU I/O register file, mailbox ports and three timers.
//
//  channel | dir | ports                              | beat contents
//  --------+-----+------------------------------------+---------------------------------------
//  req     | in  | req_tvalid req_tready req_tdata    | one bus cycle: operation, address, data
//  rsp     | out | rsp_tvalid rsp_tready rsp_tdata    | read byte, status flags, DSP address
//
// Decode, timer advance and register update for a request beat are one pass of logic
// from the register state to the result register, so a beat can be taken every cycle
// while rsp is not stalled. The result register is the only buffer; a new beat is taken
// whenever it is empty or is being drained in the same cycle. A stall on rsp holds the
// result and stops req. Synchronous active-high reset returns the state registers to their
// power-on values (TEST = 0A, boot ROM on) and empties the result register.
module sound_cpu_io_timer_unit_top #(
   parameter int SLOW_TIMER_PERIOD = scit_pkg::SLOW_TIMER_PERIOD_DEF,
   parameter int FAST_TIMER_PERIOD = scit_pkg::FAST_TIMER_PERIOD_DEF,
   parameter int TICKS_PER_ACCESS  = scit_pkg::TICKS_PER_ACCESS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] operation, [6:3] register_address, [14:7] write_data, [15] direct_page_flag
   input  logic [scit_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] read_data, [8] boot_rom_enabled, [9] ram_write_allowed, [10] ram_blocked,
   // [18:11] dsp_register_address, [23:19] zero
   output logic [scit_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [7:0] SLOW_PERIOD = 8'(SLOW_TIMER_PERIOD);
   localparam logic [7:0] FAST_PERIOD = 8'(FAST_TIMER_PERIOD);
   localparam logic [7:0] TICK_STEP   = 8'(TICKS_PER_ACCESS);

   // architectural state
   scit_pkg::timer_type timers_ff [scit_pkg::NUM_TIMERS];
   scit_pkg::timer_type timers_in [scit_pkg::NUM_TIMERS];
   logic [7:0]          h2c_ff    [scit_pkg::NUM_PORTS];
   logic [7:0]          h2c_in    [scit_pkg::NUM_PORTS];
   logic [7:0]          c2h_ff    [scit_pkg::NUM_PORTS];
   logic [7:0]          c2h_in    [scit_pkg::NUM_PORTS];
   logic [7:0]          aux_ff    [scit_pkg::NUM_AUX];
   logic [7:0]          aux_in    [scit_pkg::NUM_AUX];
   logic [7:0]          dsp_addr_ff, dsp_addr_in;
   logic [7:0]          test_ff, test_in;
   logic                boot_ff, boot_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [scit_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   scit_pkg::op_type op;
   logic [3:0]       addr;
   logic [7:0]       wdata;
   logic             pflag;
   logic             req_fire;
   logic [7:0]       rdata;

   assign op    = scit_pkg::op_type'(req_tdata[2:0]);
   assign addr  = req_tdata[6:3];
   assign wdata = req_tdata[14:7];
   assign pflag = req_tdata[15];

   // take a beat whenever the result slot is free or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin : next_state
      logic [7:0] sum;
      logic [7:0] period;
      timers_in   = timers_ff;
      h2c_in      = h2c_ff;
      c2h_in      = c2h_ff;
      aux_in      = aux_ff;
      dsp_addr_in = dsp_addr_ff;
      test_in     = test_ff;
      boot_in     = boot_ff;
      rdata       = '0;
      sum         = '0;
      period      = '0;

      if (req_fire) begin
         // every sound-CPU cycle advances the prescalers before the access is decoded
         if (op == scit_pkg::OP_IDLE || op == scit_pkg::OP_CPU_READ ||
             op == scit_pkg::OP_CPU_WRITE) begin
            for (int t = 0; t < scit_pkg::NUM_TIMERS; t++) begin
               period = (t == scit_pkg::NUM_TIMERS - 1) ? FAST_PERIOD : SLOW_PERIOD;
               sum    = timers_ff[t].prescale + TICK_STEP;
               timers_in[t].prescale = sum;
               if (sum >= period) begin
                  timers_in[t].prescale = sum - period;
                  timers_in[t].toggle   = ~timers_ff[t].toggle;
                  timers_in[t] = scit_pkg::timer_sync(timers_in[t], test_ff);
               end
            end
         end

         case (op)
            scit_pkg::OP_CPU_READ: begin
               case (addr)
                  scit_pkg::ADDR_DSP_ADDR: rdata = dsp_addr_ff;
                  scit_pkg::ADDR_PORT0, scit_pkg::ADDR_PORT1,
                  scit_pkg::ADDR_PORT2, scit_pkg::ADDR_PORT3: rdata = h2c_ff[addr[1:0]];
                  scit_pkg::ADDR_AUX0, scit_pkg::ADDR_AUX1: rdata = aux_ff[addr[0]];
                  // output counters clear on read
                  scit_pkg::ADDR_COUNTER0: begin
                     rdata = {4'd0, timers_in[0].tick};
                     timers_in[0].tick = '0;
                  end
                  scit_pkg::ADDR_COUNTER1: begin
                     rdata = {4'd0, timers_in[1].tick};
                     timers_in[1].tick = '0;
                  end
                  scit_pkg::ADDR_COUNTER2: begin
                     rdata = {4'd0, timers_in[2].tick};
                     timers_in[2].tick = '0;
                  end
                  default: rdata = '0;   // write-only registers and DSP data read as zero
               endcase
            end
            scit_pkg::OP_CPU_WRITE: begin
               case (addr)
                  scit_pkg::ADDR_TEST: begin
                     if (!pflag) begin
                        test_in = wdata;
                        for (int t = 0; t < scit_pkg::NUM_TIMERS; t++) begin
                           timers_in[t] = scit_pkg::timer_sync(timers_in[t], wdata);
                        end
                     end
                  end
                  scit_pkg::ADDR_CONTROL: begin
                     if (wdata[scit_pkg::CTRL_CLEAR_LOW_BIT]) begin
                        h2c_in[0] = '0;
                        h2c_in[1] = '0;
                     end
                     if (wdata[scit_pkg::CTRL_CLEAR_HIGH_BIT]) begin
                        h2c_in[2] = '0;
                        h2c_in[3] = '0;
                     end
                     boot_in = wdata[scit_pkg::CTRL_BOOT_ROM_BIT];
                     // a rising enable restarts the divider and output counter
                     for (int t = 0; t < scit_pkg::NUM_TIMERS; t++) begin
                        if (!timers_in[t].on && wdata[t]) begin
                           timers_in[t].divider = '0;
                           timers_in[t].tick    = '0;
                        end
                        timers_in[t].on = wdata[t];
                     end
                  end
                  scit_pkg::ADDR_DSP_ADDR: dsp_addr_in = wdata;
                  scit_pkg::ADDR_PORT0, scit_pkg::ADDR_PORT1,
                  scit_pkg::ADDR_PORT2, scit_pkg::ADDR_PORT3: c2h_in[addr[1:0]] = wdata;
                  scit_pkg::ADDR_AUX0, scit_pkg::ADDR_AUX1: aux_in[addr[0]] = wdata;
                  scit_pkg::ADDR_TARGET0: timers_in[0].target = wdata;
                  scit_pkg::ADDR_TARGET1: timers_in[1].target = wdata;
                  scit_pkg::ADDR_TARGET2: timers_in[2].target = wdata;
                  default: ;   // DSP data and output counters drop writes
               endcase
            end
            scit_pkg::OP_HOST_READ:  rdata = c2h_ff[addr[1:0]];
            scit_pkg::OP_HOST_WRITE: h2c_in[addr[1:0]] = wdata;
            default: ;   // idle and unused codes touch nothing more
         endcase
      end
   end

   // result beat reports the state after this cycle's effects
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, dsp_addr_in,
                         test_in[scit_pkg::TEST_RAM_BLOCK_BIT],
                         test_in[scit_pkg::TEST_RAM_WRITE_BIT],
                         boot_in, rdata};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < scit_pkg::NUM_TIMERS; t++) begin
            timers_ff[t] <= '0;
         end
         for (int p = 0; p < scit_pkg::NUM_PORTS; p++) begin
            h2c_ff[p] <= '0;
            c2h_ff[p] <= '0;
         end
         for (int x = 0; x < scit_pkg::NUM_AUX; x++) begin
            aux_ff[x] <= '0;
         end
         dsp_addr_ff  <= '0;
         test_ff      <= scit_pkg::TEST_RESET;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         timers_ff    <= timers_in;
         h2c_ff       <= h2c_in;
         c2h_ff       <= c2h_in;
         aux_ff       <= aux_in;
         dsp_addr_ff  <= dsp_addr_in;
         test_ff      <= test_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sim/scit_bus_checker.sv @@
`timescale 1ns / 1ps
// Response checker for the sound-CPU I/O timer unit: predicts every response beat and compares it.
module scit_bus_checker
   import scit_pkg::*;
#(
   parameter int SLOW_PERIOD = SLOW_TIMER_PERIOD_DEF,
   parameter int FAST_PERIOD = FAST_TIMER_PERIOD_DEF,
   parameter int TICKS       = TICKS_PER_ACCESS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    awaited,
   output int                    beats_compared,
   output int                    ticks_observed
);

   typedef struct packed {
      logic [7:0] read_byte;
      logic       boot_rom;
      logic       ram_write;
      logic       ram_block;
      logic [7:0] dsp_addr;
   } bus_reply;

   logic [7:0] prescale_q [NUM_TIMERS];
   logic       toggle_q   [NUM_TIMERS];
   logic       gate_q     [NUM_TIMERS];
   logic       running_q  [NUM_TIMERS];
   logic [7:0] target_q   [NUM_TIMERS];
   logic [7:0] divider_q  [NUM_TIMERS];
   logic [3:0] ticks_q    [NUM_TIMERS];
   logic [7:0] to_cpu_q   [NUM_PORTS];
   logic [7:0] to_host_q  [NUM_PORTS];
   logic [7:0] aux_q      [NUM_AUX];
   logic [7:0] dsp_addr_q;
   logic [7:0] test_q;
   logic       boot_q;

   bus_reply reply_q [$];
   int       fail_total;
   int       compare_total;
   int       tick_total;

   initial begin
      fail_total    = 0;
      compare_total = 0;
      tick_total    = 0;
   end

   function automatic void reset_model();
      for (int t = 0; t < NUM_TIMERS; t++) begin
         prescale_q[t] = '0;
         toggle_q[t]   = 1'b0;
         gate_q[t]     = 1'b0;
         running_q[t]  = 1'b0;
         target_q[t]   = '0;
         divider_q[t]  = '0;
         ticks_q[t]    = '0;
      end
      for (int p = 0; p < NUM_PORTS; p++) begin
         to_cpu_q[p]  = '0;
         to_host_q[p] = '0;
      end
      for (int a = 0; a < NUM_AUX; a++) aux_q[a] = '0;
      dsp_addr_q = '0;
      test_q     = TEST_RESET;
      boot_q     = 1'b1;
   endfunction

   // Falling edge of the gated square wave steps the divider; hitting the target
   // (zero acts as 256 through the wrap) bumps the 4-bit output.
   function automatic void resample_gate(int t);
      logic level;
      logic fell;
      level = toggle_q[t] & test_q[TEST_TIMER_ENABLE_BIT] & ~test_q[TEST_TIMER_DISABLE_BIT];
      fell  = gate_q[t] & ~level;
      gate_q[t] = level;
      if (fell && running_q[t]) begin
         divider_q[t] = divider_q[t] + 8'd1;
         if (divider_q[t] == target_q[t]) begin
            divider_q[t] = '0;
            ticks_q[t]   = ticks_q[t] + 4'd1;
         end
      end
   endfunction

   function automatic void prescale_step(int t, int period);
      prescale_q[t] = prescale_q[t] + 8'(TICKS);
      if (int'(prescale_q[t]) >= period) begin
         prescale_q[t] = prescale_q[t] - 8'(period);
         toggle_q[t]   = ~toggle_q[t];
         resample_gate(t);
      end
   endfunction

   function automatic logic [7:0] io_read_effect(logic [3:0] addr);
      logic [7:0] v;
      int         idx;
      v = '0;
      case (addr)
         ADDR_DSP_ADDR: v = dsp_addr_q;
         ADDR_PORT0, ADDR_PORT1, ADDR_PORT2, ADDR_PORT3: v = to_cpu_q[addr[1:0]];
         ADDR_AUX0, ADDR_AUX1: v = aux_q[addr[0]];
         ADDR_COUNTER0, ADDR_COUNTER1, ADDR_COUNTER2: begin
            idx          = int'(addr - ADDR_COUNTER0);
            v            = {4'd0, ticks_q[idx]};
            ticks_q[idx] = '0;
            if (v != 0) tick_total++;
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic void io_write_effect(logic [3:0] addr, logic [7:0] d, logic pflag);
      case (addr)
         ADDR_TEST: begin
            if (!pflag) begin
               test_q = d;
               for (int t = 0; t < NUM_TIMERS; t++) resample_gate(t);
            end
         end
         ADDR_CONTROL: begin
            if (d[CTRL_CLEAR_LOW_BIT]) begin
               to_cpu_q[0] = '0;
               to_cpu_q[1] = '0;
            end
            if (d[CTRL_CLEAR_HIGH_BIT]) begin
               to_cpu_q[2] = '0;
               to_cpu_q[3] = '0;
            end
            boot_q = d[CTRL_BOOT_ROM_BIT];
            // only a rising enable restarts the divider and output
            for (int t = 0; t < NUM_TIMERS; t++) begin
               if (!running_q[t] && d[t]) begin
                  divider_q[t] = '0;
                  ticks_q[t]   = '0;
               end
               running_q[t] = d[t];
            end
         end
         ADDR_DSP_ADDR: dsp_addr_q = d;
         ADDR_PORT0, ADDR_PORT1, ADDR_PORT2, ADDR_PORT3: to_host_q[addr[1:0]] = d;
         ADDR_AUX0, ADDR_AUX1: aux_q[addr[0]] = d;
         ADDR_TARGET0, ADDR_TARGET1, ADDR_TARGET2: target_q[int'(addr - ADDR_TARGET0)] = d;
         default: ;
      endcase
   endfunction

   function automatic bus_reply predict_cycle(logic [REQ_DATA_W-1:0] beat);
      logic [2:0] op;
      logic [3:0] addr;
      logic [7:0] wdata;
      logic       pflag;
      bus_reply   r;
      op    = beat[2:0];
      addr  = beat[6:3];
      wdata = beat[14:7];
      pflag = beat[15];
      r.read_byte = '0;
      // every sound-CPU cycle, idle included, moves the timers first
      if (op <= OP_CPU_WRITE) begin
         prescale_step(0, SLOW_PERIOD);
         prescale_step(1, SLOW_PERIOD);
         prescale_step(2, FAST_PERIOD);
      end
      case (op)
         OP_CPU_READ:   r.read_byte = io_read_effect(addr);
         OP_CPU_WRITE:  io_write_effect(addr, wdata, pflag);
         OP_HOST_READ:  r.read_byte = to_host_q[addr[1:0]];
         OP_HOST_WRITE: to_cpu_q[addr[1:0]] = wdata;
         default: ;
      endcase
      r.boot_rom  = boot_q;
      r.ram_write = test_q[TEST_RAM_WRITE_BIT];
      r.ram_block = test_q[TEST_RAM_BLOCK_BIT];
      r.dsp_addr  = dsp_addr_q;
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         fail_total++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      bus_reply want;
      if (reset) begin
         reset_model();
         reply_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_q.size() == 0) begin
               fail_total++;
               $display("%0t ns: response beat with nothing expected, expected none, actual 0x%06h",
                        $time, rsp_tdata);
            end else begin
               want = reply_q.pop_front();
               compare_total++;
               check_field("read_data", want.read_byte, rsp_tdata[7:0]);
               check_field("boot_rom_enabled", want.boot_rom, rsp_tdata[8]);
               check_field("ram_write_allowed", want.ram_write, rsp_tdata[9]);
               check_field("ram_blocked", want.ram_block, rsp_tdata[10]);
               check_field("dsp_register_address", want.dsp_addr, rsp_tdata[18:11]);
               check_field("pad bits", 0, rsp_tdata[23:19]);
            end
         end
         if (req_tvalid && req_tready) reply_q.push_back(predict_cycle(req_tdata));
      end
      mismatches     <= fail_total;
      awaited        <= reply_q.size();
      beats_compared <= compare_total;
      ticks_observed <= tick_total;
   end

endmodule

@@ sim/sound_cpu_io_timer_unit_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the sound-CPU I/O timer unit: stimulus, handshake pacing and verdict.
module sound_cpu_io_timer_unit_top_tb;
   import scit_pkg::*;

   // Opcodes past the defined set; the block must treat them as no-ops.
   localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

   localparam int BEAT_BUDGET      = 1650;
   localparam int QUIET_TAIL_START = 1450;
   localparam int LONG_HOLD_AT     = 500;
   localparam int DRAIN_PAUSE_AT   = 1000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT      = 5000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // [2:0] operation, [6:3] register_address, [14:7] write_data, [15] direct_page_flag
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [7:0] read_data, [8] boot_rom_enabled, [9] ram_write_allowed, [10] ram_blocked,
   // [18:11] dsp_register_address, [23:19] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_total;
   int awaited;
   int beats_compared;
   int ticks_observed;

   // Pacing knobs shared between the sender and the receiver processes.
   int gap_pct        = 0;
   int stall_pct      = 0;
   bit long_hold_req  = 1'b0;
   int beats_sent     = 0;
   int timer_runs     = 0;
   int mailbox_runs   = 0;
   int noise_runs     = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sound_cpu_io_timer_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   scit_bus_checker bus_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatches     (fail_total),
      .awaited        (awaited),
      .beats_compared (beats_compared),
      .ticks_observed (ticks_observed)
   );

   // Offer one request beat and hold it until the block takes it. A random gap
   // may come first; valid is never dropped and raised on the same edge.
   task automatic issue_beat(input logic [2:0] op, input logic [3:0] addr,
                             input logic [7:0] wdata, input logic pflag);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pflag, wdata, addr, op};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic cpu_wr(input logic [3:0] addr, input logic [7:0] wdata);
      issue_beat(OP_CPU_WRITE, addr, wdata, 1'b0);
   endtask

   // Reads carry random data and P flag so those bits toggle on the read opcode too.
   task automatic cpu_rd(input logic [3:0] addr);
      issue_beat(OP_CPU_READ, addr, 8'($urandom), 1'($urandom));
   endtask

   // Drop valid and wait until every predicted response has come back; ok reports whether they did.
   task automatic wait_drained(output bit ok);
      int spin;
      spin = 0;
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
         spin++;
      end while (awaited != 0 && spin < DRAIN_LIMIT);
      ok = (awaited == 0);
   endtask

   function automatic logic [7:0] pick_target();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 14) return 8'($urandom_range(1, 4));
      if (roll < 17) return 8'd0;
      return 8'($urandom);
   endfunction

   // Well-formed timer setup: TEST, targets, CONTROL, then a run of bus cycles
   // with scattered accesses, and finally read back all three outputs.
   task automatic run_timer_sequence();
      logic [7:0] test_val;
      logic [7:0] ctrl_val;
      int         run_len;
      int         pick;
      test_val = 8'($urandom);
      test_val[TEST_TIMER_ENABLE_BIT]  = ($urandom_range(0, 5) != 0);
      test_val[TEST_TIMER_DISABLE_BIT] = ($urandom_range(0, 5) == 0);
      issue_beat(OP_CPU_WRITE, ADDR_TEST, test_val, ($urandom_range(0, 7) == 0));
      cpu_wr(ADDR_TARGET0, pick_target());
      cpu_wr(ADDR_TARGET1, pick_target());
      cpu_wr(ADDR_TARGET2, pick_target());
      ctrl_val      = 8'($urandom);
      ctrl_val[2:0] = 3'($urandom_range(1, 7));
      cpu_wr(ADDR_CONTROL, ctrl_val);
      run_len = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 300) : $urandom_range(10, 80);
      repeat (run_len) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3, 4: issue_beat(OP_IDLE, 4'($urandom), 8'($urandom), 1'($urandom));
            5: cpu_rd(4'($urandom_range(ADDR_COUNTER0, ADDR_COUNTER2)));
            6: issue_beat(OP_HOST_WRITE, 4'($urandom), 8'($urandom), 1'($urandom));
            7: cpu_rd(4'($urandom));
            8: cpu_wr(4'($urandom_range(ADDR_DSP_ADDR, ADDR_COUNTER2)), 8'($urandom));
            default: issue_beat(OP_HOST_READ, 4'($urandom), 8'($urandom), 1'($urandom));
         endcase
      end
      cpu_rd(ADDR_COUNTER0);
      cpu_rd(ADDR_COUNTER1);
      cpu_rd(ADDR_COUNTER2);
      timer_runs++;
   endtask

   // Mailbox traffic from both sides of the four ports.
   task automatic run_mailbox_burst();
      repeat ($urandom_range(4, 20)) begin
         case ($urandom_range(0, 3))
            0: issue_beat(OP_HOST_WRITE, 4'($urandom), 8'($urandom), 1'($urandom));
            1: issue_beat(OP_HOST_READ, 4'($urandom), 8'($urandom), 1'($urandom));
            2: cpu_wr(4'($urandom_range(ADDR_PORT0, ADDR_PORT3)), 8'($urandom));
            default: cpu_rd(4'($urandom_range(ADDR_PORT0, ADDR_PORT3)));
         endcase
      end
      mailbox_runs++;
   endtask

   // Unstructured beats, reserved opcodes included now and then.
   task automatic run_noise_burst();
      logic [2:0] op;
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 15) == 0)
            op = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
         else
            op = 3'($urandom_range(OP_IDLE, OP_HOST_WRITE));
         issue_beat(op, 4'($urandom), 8'($urandom), 1'($urandom));
      end
      noise_runs++;
   endtask

   // Receiver: random stall bursts, one long hold-off on request, none when quiet.
   initial begin : ready_gen
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_left = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      bit held;
      bit paused;
      bit drained;
      int scenario;
      held    = 1'b0;
      paused  = 1'b0;
      drained = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: write-only reads, field extremes, port aliasing, P-flag lockout,
      // ignored writes, port clearing, boot flag, a timer start and reserved opcodes.
      issue_beat(OP_IDLE, 4'h0, 8'h00, 1'b0);
      cpu_rd(ADDR_TEST);
      cpu_rd(ADDR_CONTROL);
      cpu_wr(ADDR_DSP_ADDR, 8'hFF);
      cpu_rd(ADDR_DSP_ADDR);
      cpu_rd(ADDR_DSP_DATA);
      cpu_wr(ADDR_DSP_DATA, 8'hFF);
      issue_beat(OP_HOST_WRITE, 4'hF, 8'hFF, 1'b1);
      cpu_rd(ADDR_PORT3);
      cpu_wr(ADDR_PORT0, 8'h5A);
      issue_beat(OP_HOST_READ, 4'hC, 8'h00, 1'b0);
      cpu_wr(ADDR_AUX1, 8'hA5);
      cpu_rd(ADDR_AUX1);
      issue_beat(OP_CPU_WRITE, ADDR_TEST, 8'hFF, 1'b1);
      cpu_wr(ADDR_TEST, 8'hFF);
      cpu_wr(ADDR_TEST, TEST_RESET);
      cpu_wr(ADDR_COUNTER2, 8'hFF);
      cpu_wr(ADDR_TARGET2, 8'h01);
      cpu_wr(ADDR_CONTROL, 8'h34);
      cpu_rd(ADDR_PORT3);
      for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
         issue_beat(3'(op), 4'hF, 8'hFF, 1'b1);
      cpu_rd(ADDR_COUNTER2);
      cpu_wr(ADDR_CONTROL, 8'h80);

      // Random: mostly timer sequences, some mailbox traffic, a little noise.
      while (beats_sent < BEAT_BUDGET) begin
         if (beats_sent >= QUIET_TAIL_START) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
         end
         // Back-pressure: stall the receiver long enough to block req while offering beats.
         if (!held && beats_sent >= LONG_HOLD_AT) begin
            held          = 1'b1;
            gap_pct       = 0;
            long_hold_req = 1'b1;
         end
         // Let the pipe run dry once mid-run before continuing.
         if (!paused && beats_sent >= DRAIN_PAUSE_AT) begin
            paused = 1'b1;
            wait_drained(drained);
         end
         scenario = $urandom_range(0, 19);
         if (scenario < 12) run_timer_sequence();
         else if (scenario < 17) run_mailbox_burst();
         else run_noise_burst();
      end

      // Drain and let any trailing beat settle.
      wait_drained(drained);
      repeat (8) @(posedge clock);

      $display("Sent %0d bus cycles: %0d timer sequences, %0d mailbox bursts, %0d noise bursts.",
               beats_sent, timer_runs, mailbox_runs, noise_runs);
      $display("Compared %0d response beats; %0d timer output reads returned nonzero counts.",
               beats_compared, ticks_observed);
      if (drained && fail_total == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sound_cpu_io_timer_unit_top.f @@
rtl/scit_pkg.sv
rtl/sound_cpu_io_timer_unit_top.sv
sim/scit_bus_checker.sv
sim/sound_cpu_io_timer_unit_top_tb.sv
